### rtl/core/ght_pkg.sv
package ght_pkg;

  localparam int SLOTS   = 256;
  localparam int ID_W    = $clog2(SLOTS);
  localparam int HW_W    = ID_W + 1;
  localparam int GRP_W   = ID_W / 2;
  localparam int LEAF_W  = ID_W - GRP_W;
  localparam int NGRP    = 1 << GRP_W;
  localparam int LEAF    = 1 << LEAF_W;

  localparam int EPOCH_W = 16;
  localparam int PAY_W   = 32;
  localparam int KIND_W  = 8;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;
  localparam int MEM_W   = EPOCH_W + PAY_W;

  localparam logic [REQ_W-1:0] REQ_ADD     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  localparam logic [KIND_W-1:0] OWN_KIND_RST = 8'd1;

  // search sequencing from the controller
  typedef struct packed {
    logic grp_en;
    logic sel_en;
  } srch_ctl_t;

  // search answer, valid in the cycle after sel_en
  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] pick;
  } srch_res_t;

endpackage

### rtl/core/ght_ram.sv
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/ght_free_search.sv
// Lowest free slot below the high-water mark, two-level registered search:
// group summary, then group select, then bit select within the group.
module ght_free_search (
  input  logic                         clk,
  input  ght_pkg::srch_ctl_t           ctl,
  input  logic [ght_pkg::SLOTS-1:0]    occ,
  input  logic [ght_pkg::HW_W-1:0]     hw,
  output ght_pkg::srch_res_t           res
);

  logic [ght_pkg::SLOTS-1:0]  free_mask;
  logic [ght_pkg::NGRP-1:0]   grp_any;
  logic [ght_pkg::NGRP-1:0]   grp_flags;
  logic [ght_pkg::GRP_W-1:0]  grp_pick;
  logic [ght_pkg::GRP_W-1:0]  grp_sel;
  logic                       grp_found;
  logic [ght_pkg::LEAF-1:0]   leaf_bits;
  logic [ght_pkg::LEAF_W-1:0] leaf_pick;

  always_comb begin
    for (int i = 0; i < ght_pkg::SLOTS; i++) begin
      free_mask[i] = !occ[i] && (i != 0) && (ght_pkg::HW_W'(i) < hw);
    end
  end

  always_comb begin
    for (int g = 0; g < ght_pkg::NGRP; g++) begin
      grp_any[g] = |free_mask[g*ght_pkg::LEAF +: ght_pkg::LEAF];
    end
  end

  always_comb begin
    grp_pick = '0;
    for (int g = ght_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_flags[g]) grp_pick = ght_pkg::GRP_W'(g);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.grp_en) begin
      grp_flags <= grp_any;
    end
    if (ctl.sel_en) begin
      grp_sel   <= grp_pick;
      grp_found <= |grp_flags;
    end
  end

  // occupancy and high-water mark hold still while the search runs
  assign leaf_bits = free_mask[{grp_sel, {ght_pkg::LEAF_W{1'b0}}} +: ght_pkg::LEAF];

  always_comb begin
    leaf_pick = '0;
    for (int b = ght_pkg::LEAF - 1; b >= 0; b--) begin
      if (leaf_bits[b]) leaf_pick = ght_pkg::LEAF_W'(b);
    end
  end

  assign res.found = grp_found;
  assign res.pick  = {grp_sel, leaf_pick};

endmodule

### rtl/core/generational_handle_table.sv
// Generational handle table.
// Input channel (in_valid/in_stall): one request transaction carries
// req_type (add, lookup, release, clear) plus handle fields and payload.
// Output channel (out_valid/out_stall): exactly one result transaction per
// request: status, out_id, out_epoch, out_payload.
// Config: cfg_we writes own_kind from cfg_wdata; write only while idle.
// One request is in flight at a time; in_stall is high while it is worked.
// The result is loaded into the output register from S_FIN: a clear goes
// straight there, lookup/release pass through S_CHK, and an add through
// S_GRP, S_SEL and S_BIT, plus S_ADDWR when it reuses a slot. The next
// request is taken the cycle after that load; a stalled output delays it.
// The add path runs the free-slot search (group summary, group select,
// bit select over the occupied flops) and the epoch/payload RAM read.
// Results sit in an output register; a new request may be accepted while
// the last result is stalled, and its own result waits until that clears.
// Reset: occupancy cleared, high-water mark 1 (sentinel only), own_kind 1,
// output empty. The epoch/payload RAM is not cleared; entries below the
// high-water mark were always written on append.
module generational_handle_table (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          cfg_we,
  input  logic [ght_pkg::KIND_W-1:0]    cfg_wdata,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ght_pkg::REQ_W-1:0]     req_type,
  input  logic [ght_pkg::ID_W-1:0]      handle_id,
  input  logic [ght_pkg::EPOCH_W-1:0]   handle_epoch,
  input  logic [ght_pkg::KIND_W-1:0]    handle_kind,
  input  logic [ght_pkg::PAY_W-1:0]     payload,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ght_pkg::STAT_W-1:0]    status,
  output logic [ght_pkg::ID_W-1:0]      out_id,
  output logic [ght_pkg::EPOCH_W-1:0]   out_epoch,
  output logic [ght_pkg::PAY_W-1:0]     out_payload
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_GRP   = 7'b0000010,  // search: group summary
    S_SEL   = 7'b0000100,  // search: group select
    S_BIT   = 7'b0001000,  // search result; append or read reused slot
    S_ADDWR = 7'b0010000,  // write back reused slot
    S_CHK   = 7'b0100000,  // handle check on RAM read data
    S_FIN   = 7'b1000000   // hand result to output register
  } state_t;

  state_t state;
  state_t state_next;

  // control state
  logic [ght_pkg::KIND_W-1:0]  own_kind;
  logic [ght_pkg::SLOTS-1:0]   occ;
  logic [ght_pkg::HW_W-1:0]    hw;

  // request captured at acceptance
  logic [ght_pkg::REQ_W-1:0]   req_r;
  logic [ght_pkg::ID_W-1:0]    id_r;
  logic [ght_pkg::EPOCH_W-1:0] ep_r;
  logic [ght_pkg::KIND_W-1:0]  kind_r;
  logic [ght_pkg::PAY_W-1:0]   data_r;
  logic [ght_pkg::ID_W-1:0]    pick_r;

  // pending result
  logic [ght_pkg::STAT_W-1:0]  res_status;
  logic [ght_pkg::ID_W-1:0]    res_id;
  logic [ght_pkg::EPOCH_W-1:0] res_epoch;
  logic [ght_pkg::PAY_W-1:0]   res_payload;

  ght_pkg::srch_ctl_t          srch_ctl;
  ght_pkg::srch_res_t          srch_res;

  logic                        mem_we;
  logic [ght_pkg::ID_W-1:0]    mem_addr;
  logic [ght_pkg::MEM_W-1:0]   mem_wdata;
  logic [ght_pkg::MEM_W-1:0]   mem_rdata;

  logic [ght_pkg::EPOCH_W-1:0] rd_epoch;
  logic [ght_pkg::PAY_W-1:0]   rd_payload;
  logic [ght_pkg::EPOCH_W-1:0] ep_sum;
  logic [ght_pkg::EPOCH_W-1:0] ep_inc;
  logic [ght_pkg::EPOCH_W-1:0] add_ep;
  logic                        can_append;
  logic                        pass;
  logic                        accept;
  logic                        out_load;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  assign rd_epoch   = mem_rdata[ght_pkg::MEM_W-1 -: ght_pkg::EPOCH_W];
  assign rd_payload = mem_rdata[ght_pkg::PAY_W-1:0];
  // release advances the epoch and skips zero on wrap
  assign ep_sum     = rd_epoch + ght_pkg::EPOCH_W'(1);
  assign ep_inc     = (ep_sum == '0) ? ght_pkg::EPOCH_W'(1) : ep_sum;
  // a reused slot never holds epoch zero, but keep the rule anyway
  assign add_ep     = (rd_epoch == '0) ? ght_pkg::EPOCH_W'(1) : rd_epoch;
  assign can_append = (hw < ght_pkg::HW_W'(ght_pkg::SLOTS));

  // handle check; occupancy and high-water mark are stable in S_CHK
  assign pass = (ep_r != '0) && (kind_r == own_kind) && (id_r != '0) &&
                ({1'b0, id_r} < hw) && occ[id_r] && (rd_epoch == ep_r);

  assign srch_ctl.grp_en = (state == S_GRP);
  assign srch_ctl.sel_en = (state == S_SEL);

  ght_free_search u_search (
    .clk (clk),
    .ctl (srch_ctl),
    .occ (occ),
    .hw  (hw),
    .res (srch_res)
  );

  ght_ram #(
    .WIDTH (ght_pkg::MEM_W),
    .DEPTH (ght_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // RAM port: read at acceptance, read-modify-write later
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = id_r;
    mem_wdata = {ep_inc, rd_payload};
    case (state)
      S_IDLE: begin
        mem_addr = handle_id;
      end
      S_BIT: begin
        if (srch_res.found) begin
          mem_addr = srch_res.pick;
        end else begin
          mem_addr  = hw[ght_pkg::ID_W-1:0];
          mem_we    = can_append;
          mem_wdata = {ght_pkg::EPOCH_W'(1), data_r};
        end
      end
      S_ADDWR: begin
        mem_addr  = pick_r;
        mem_we    = 1'b1;
        mem_wdata = {add_ep, data_r};
      end
      S_CHK: begin
        mem_addr = id_r;
        mem_we   = (req_r == ght_pkg::REQ_RELEASE) && pass;
      end
      default: begin
        mem_addr = id_r;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (req_type)
            ght_pkg::REQ_ADD:     state_next = S_GRP;
            ght_pkg::REQ_LOOKUP,
            ght_pkg::REQ_RELEASE: state_next = S_CHK;
            default:              state_next = S_FIN;
          endcase
        end
      end
      S_GRP:   state_next = S_SEL;
      S_SEL:   state_next = S_BIT;
      S_BIT:   state_next = srch_res.found ? S_ADDWR : S_FIN;
      S_ADDWR: state_next = S_FIN;
      S_CHK:   state_next = S_FIN;
      S_FIN: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      own_kind  <= ght_pkg::OWN_KIND_RST;
      occ       <= '0;
      hw        <= ght_pkg::HW_W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        own_kind <= cfg_wdata;
      end
      if (accept && (req_type == ght_pkg::REQ_CLEAR)) begin
        occ <= '0;
        hw  <= ght_pkg::HW_W'(1);
      end
      if (state == S_BIT && !srch_res.found && can_append) begin
        occ[hw[ght_pkg::ID_W-1:0]] <= 1'b1;
        hw                         <= hw + ght_pkg::HW_W'(1);
      end
      if (state == S_ADDWR) begin
        occ[pick_r] <= 1'b1;
      end
      if (state == S_CHK && req_r == ght_pkg::REQ_RELEASE && pass) begin
        occ[id_r] <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r       <= req_type;
      id_r        <= handle_id;
      ep_r        <= handle_epoch;
      kind_r      <= handle_kind;
      data_r      <= payload;
      res_status  <= ght_pkg::ST_OK;
      res_id      <= '0;
      res_epoch   <= '0;
      res_payload <= '0;
    end
    case (state)
      S_BIT: begin
        pick_r <= srch_res.pick;
        if (!srch_res.found) begin
          if (can_append) begin
            res_id    <= hw[ght_pkg::ID_W-1:0];
            res_epoch <= ght_pkg::EPOCH_W'(1);
          end else begin
            res_status <= ght_pkg::ST_FULL;
          end
        end
      end
      S_ADDWR: begin
        res_id    <= pick_r;
        res_epoch <= add_ep;
      end
      S_CHK: begin
        if (!pass) begin
          res_status <= ght_pkg::ST_REJECT;
        end else if (req_r == ght_pkg::REQ_LOOKUP) begin
          res_payload <= rd_payload;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      status      <= res_status;
      out_id      <= res_id;
      out_epoch   <= res_epoch;
      out_payload <= res_payload;
    end
  end

  // sentinel slot is never handed out
  a_sentinel_free: assert property (@(posedge clk) disable iff (rst)
    !occ[0])
    else $error("sentinel slot marked occupied");

  // full is reported only when the table really is at capacity
  a_full_at_cap: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_status == ght_pkg::ST_FULL) |->
      (hw == ght_pkg::HW_W'(ght_pkg::SLOTS)))
    else $error("table full reported below capacity");

  // the high-water mark only grows on an append
  a_hw_grow: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (hw > $past(hw))) |-> ($past(state) == S_BIT))
    else $error("high-water mark grew outside append");

endmodule

### tb/generational_handle_table_tb.sv
`timescale 1ns / 1ps

module generational_handle_table_tb;

  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
  localparam int LONG_HOLD      = 300;   // receiver hold-off, fills the block
  localparam int MAX_PRINTS     = 30;

  // One request transaction as the sender presents it.
  typedef struct packed {
    logic [ght_pkg::REQ_W-1:0]   op;
    logic [ght_pkg::ID_W-1:0]    id;
    logic [ght_pkg::EPOCH_W-1:0] ep;
    logic [ght_pkg::KIND_W-1:0]  kind;
    logic [ght_pkg::PAY_W-1:0]   data;
  } request_t;

  // One result transaction.
  typedef struct packed {
    logic [ght_pkg::STAT_W-1:0]  st;
    logic [ght_pkg::ID_W-1:0]    id;
    logic [ght_pkg::EPOCH_W-1:0] ep;
    logic [ght_pkg::PAY_W-1:0]   pay;
  } result_t;

  typedef struct packed {
    logic [ght_pkg::ID_W-1:0]    id;
    logic [ght_pkg::EPOCH_W-1:0] ep;
  } handle_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [ght_pkg::KIND_W-1:0]   cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [ght_pkg::REQ_W-1:0]    req_type = '0;
  logic [ght_pkg::ID_W-1:0]     handle_id = '0;
  logic [ght_pkg::EPOCH_W-1:0]  handle_epoch = '0;
  logic [ght_pkg::KIND_W-1:0]   handle_kind = '0;
  logic [ght_pkg::PAY_W-1:0]    payload = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ght_pkg::STAT_W-1:0]   status;
  logic [ght_pkg::ID_W-1:0]     out_id;
  logic [ght_pkg::EPOCH_W-1:0]  out_epoch;
  logic [ght_pkg::PAY_W-1:0]    out_payload;

  generational_handle_table dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .handle_id    (handle_id),
    .handle_epoch (handle_epoch),
    .handle_kind  (handle_kind),
    .payload      (payload),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_id       (out_id),
    .out_epoch    (out_epoch),
    .out_payload  (out_payload)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow table. Updated in acceptance order by the monitor.
  // ---------------------------------------------------------------------
  bit                           in_use   [ght_pkg::SLOTS];
  logic [ght_pkg::EPOCH_W-1:0]  gen_of   [ght_pkg::SLOTS];  // unwritten entries stay X
  logic [ght_pkg::PAY_W-1:0]    data_of  [ght_pkg::SLOTS];
  int                           hw_mark;           // next slot to append
  logic [ght_pkg::KIND_W-1:0]   accept_kind;

  // Handles the generator can aim at: currently live, and recently freed.
  handle_t             live_handles[$];
  handle_t             dead_handles[$];
  int                  full_answers;

  request_t            pending_reqs[$];
  result_t             expected_results[$];
  int                  mismatches;

  bit                  req_taken;     // input transaction at the last rising edge
  bit                  calm;          // no idling on either side
  int                  rx_hold_asks;  // bumped by the sequencer for a long hold
  int                  rx_hold_done;
  int                  rx_left;
  int                  tx_gap;
  int                  quiet_cycles;

  task automatic reset_table();
    for (int i = 0; i < ght_pkg::SLOTS; i++) in_use[i] = 1'b0;
    hw_mark = 1;  // only the sentinel
    accept_kind = ght_pkg::OWN_KIND_RST;
    live_handles.delete();
    dead_handles.delete();
  endtask

  function automatic bit handle_passes(request_t r);
    return r.ep != '0 && r.kind == accept_kind && r.id != '0 &&
           int'(r.id) < hw_mark && in_use[r.id] && gen_of[r.id] == r.ep;
  endfunction

  // Applies one request to the shadow table and returns the result it owes.
  function automatic result_t apply_request(request_t r);
    result_t                     res;
    handle_t                     h;
    int                          pick;
    logic [ght_pkg::EPOCH_W-1:0] nxt;
    res = '0;
    case (r.op)
      ght_pkg::REQ_ADD: begin
        pick = 0;
        for (int i = 1; i < hw_mark; i++) begin
          if (!in_use[i]) begin
            pick = i;
            break;
          end
        end
        if (pick == 0) begin
          if (hw_mark < ght_pkg::SLOTS) begin
            // append: fresh slot always starts at generation 1
            pick = hw_mark;
            gen_of[pick] = ght_pkg::EPOCH_W'(1);
            hw_mark++;
          end
        end else if (gen_of[pick] == '0) begin
          gen_of[pick] = ght_pkg::EPOCH_W'(1);
        end
        if (pick == 0) begin
          res.st = ght_pkg::ST_FULL;
          full_answers++;
        end else begin
          in_use[pick] = 1'b1;
          data_of[pick] = r.data;
          res.st = ght_pkg::ST_OK;
          res.id = ght_pkg::ID_W'(pick);
          res.ep = gen_of[pick];
          h.id = res.id;
          h.ep = res.ep;
          live_handles = {live_handles, h};
        end
      end
      ght_pkg::REQ_LOOKUP: begin
        if (handle_passes(r)) begin
          res.st = ght_pkg::ST_OK;
          res.pay = data_of[r.id];
        end else begin
          res.st = ght_pkg::ST_REJECT;
        end
      end
      ght_pkg::REQ_RELEASE: begin
        if (handle_passes(r)) begin
          // bump generation so old handles go stale; never land on 0
          nxt = gen_of[r.id] + 1'b1;
          if (nxt == '0) nxt = ght_pkg::EPOCH_W'(1);
          in_use[r.id] = 1'b0;
          gen_of[r.id] = nxt;
          for (int i = 0; i < live_handles.size(); i++) begin
            if (live_handles[i].id == r.id) begin
              live_handles.delete(i);
              break;
            end
          end
          h.id = r.id;
          h.ep = r.ep;
          dead_handles = {dead_handles, h};
          if (dead_handles.size() > 32) void'(dead_handles.pop_front());
          res.st = ght_pkg::ST_OK;
        end else begin
          res.st = ght_pkg::ST_REJECT;
        end
      end
      default: begin
        // clear: occupancy and high-water mark only, generations untouched
        for (int i = 0; i < ght_pkg::SLOTS; i++) in_use[i] = 1'b0;
        hw_mark = 1;
        live_handles.delete();
        res.st = ght_pkg::ST_OK;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------
  // Monitor: register writes, result checks, then prediction for any
  // request taken at this edge. A result never belongs to a request taken
  // at the same edge, so checking first keeps the pairing right.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t  want;
    request_t got;
    req_taken = 1'b0;
    if (rst) begin
      reset_table();
    end else begin
      if (cfg_we) accept_kind = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result st=%0d id=%0d with no request outstanding",
                                    status, out_id));
        end else begin
          want = expected_results.pop_front();
          if (status !== want.st || out_id !== want.id || out_epoch !== want.ep ||
              out_payload !== want.pay)
            report_mismatch($sformatf(
              "got st=%0d id=%0d ep=%0d pay=%h, want st=%0d id=%0d ep=%0d pay=%h",
              status, out_id, out_epoch, out_payload,
              want.st, want.id, want.ep, want.pay));
        end
      end
      if (in_valid && !in_stall) begin
        req_taken = 1'b1;
        got.op = req_type;
        got.id = handle_id;
        got.ep = handle_epoch;
        got.kind = handle_kind;
        got.data = payload;
        expected_results = {expected_results, apply_request(got)};
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: holds a stalled transaction steady, otherwise takes the next
  // pending request, with random idle bursts between transactions.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : driver
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else if (in_valid && !req_taken) begin
      // stalled: payload stays put
    end else if (tx_gap > 0) begin
      tx_gap <= tx_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      nxt = pending_reqs.pop_front();
      req_type <= nxt.op;
      handle_id <= nxt.id;
      handle_epoch <= nxt.ep;
      handle_kind <= nxt.kind;
      payload <= nxt.data;
      in_valid <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) tx_gap <= $urandom_range(1, 10);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver back-pressure: short random bursts, plus one long hold-off on
  // request so the output register and the input side both back up.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_left <= 0;
      rx_hold_done <= 0;
    end else if (rx_hold_asks != rx_hold_done) begin
      rx_hold_done <= rx_hold_asks;
      rx_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      rx_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: too long without any transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------
  task automatic settle();
    @(posedge clk);
    #1;
  endtask

  function automatic request_t req(int unsigned op, int unsigned id, int unsigned ep,
                                   int unsigned kind, int unsigned data);
    request_t r;
    r.op = ght_pkg::REQ_W'(op);
    r.id = ght_pkg::ID_W'(id);
    r.ep = ght_pkg::EPOCH_W'(ep);
    r.kind = ght_pkg::KIND_W'(kind);
    r.data = ght_pkg::PAY_W'(data);
    return r;
  endfunction

  // Keep the pending queue short so generated handles track the table.
  task automatic send(request_t r);
    while (pending_reqs.size() >= 3) settle();
    pending_reqs = {pending_reqs, r};
  endtask

  // Wait until the block is idle with nothing owed, then a short pause.
  task automatic drain();
    do settle(); while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (8) settle();
  endtask

  task automatic write_kind(logic [ght_pkg::KIND_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random request from a weighted mix. Lookups and releases mostly carry
  // live handles; the "bad" share breaks one part of a handle at a time.
  function automatic request_t random_request(int w_add, int w_look, int w_rel,
                                              int w_bad, int w_clr);
    request_t r;
    handle_t  h;
    int       roll;
    int       good;
    r = req($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom);
    case ($urandom_range(0, 9))
      0: r.data = '0;
      1: r.data = '1;
      default: ;
    endcase
    good = w_add + w_look + w_rel;
    roll = $urandom_range(0, good + w_bad + w_clr - 1);
    if (roll < w_add || (roll < good && live_handles.size() == 0)) begin
      r.op = ght_pkg::REQ_ADD;
    end else if (roll < good) begin
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      r.op = (roll < w_add + w_look) ? ght_pkg::REQ_LOOKUP : ght_pkg::REQ_RELEASE;
      r.id = h.id;
      r.ep = h.ep;
      r.kind = accept_kind;
    end else if (roll < good + w_bad) begin
      r.op = $urandom_range(0, 1) ? ght_pkg::REQ_LOOKUP : ght_pkg::REQ_RELEASE;
      if (live_handles.size() != 0) begin
        h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        r.id = h.id;
        r.ep = h.ep;
        r.kind = accept_kind;
      end
      case ($urandom_range(0, 5))
        0: ;  // whatever the random fields are
        1: begin
          if (dead_handles.size() != 0) begin
            h = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
            r.id = h.id;
            r.ep = h.ep;
          end
        end
        2: r.kind = accept_kind ^ ght_pkg::KIND_W'($urandom_range(1, 255));
        3: r.ep = r.ep + ght_pkg::EPOCH_W'($urandom_range(1, 3));
        4: r.id = (hw_mark >= ght_pkg::SLOTS || $urandom_range(0, 3) == 0) ? '0 :
                  ght_pkg::ID_W'($urandom_range(hw_mark, ght_pkg::SLOTS - 1));
        default: r.ep = '0;
      endcase
    end else begin
      r.op = ght_pkg::REQ_CLEAR;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : sequencer
    logic [ght_pkg::EPOCH_W-1:0] ep;
    logic [ght_pkg::EPOCH_W-1:0] last;
    int                          k;

    calm = 1'b0;
    rx_hold_asks = 0;
    mismatches = 0;
    full_answers = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, payload extremes, every rejection reason,
    // reuse of the lowest free slot, stale handles, clear.
    send(req(ght_pkg::REQ_LOOKUP,  1, 1, ght_pkg::OWN_KIND_RST, $urandom));  // nothing yet
    send(req(ght_pkg::REQ_RELEASE, 0, 1, ght_pkg::OWN_KIND_RST, $urandom));  // sentinel
    send(req(ght_pkg::REQ_ADD, $urandom, $urandom, $urandom, 32'h0000_0000));
    send(req(ght_pkg::REQ_ADD, $urandom, $urandom, $urandom, 32'hFFFF_FFFF));
    send(req(ght_pkg::REQ_ADD, $urandom, $urandom, $urandom, 32'h5A5A_A5A5));
    send(req(ght_pkg::REQ_LOOKUP,  1, 1, ght_pkg::OWN_KIND_RST, $urandom));
    send(req(ght_pkg::REQ_LOOKUP,  2, 1, ght_pkg::OWN_KIND_RST, $urandom));
    send(req(ght_pkg::REQ_LOOKUP,  2, 0, ght_pkg::OWN_KIND_RST, $urandom));  // epoch 0
    send(req(ght_pkg::REQ_LOOKUP,  2, 1, 0, $urandom));                      // wrong kind
    send(req(ght_pkg::REQ_LOOKUP,  2, 1, 8'hFF, $urandom));
    send(req(ght_pkg::REQ_LOOKUP,  0, 1, ght_pkg::OWN_KIND_RST, $urandom));
    send(req(ght_pkg::REQ_LOOKUP,  4, 1, ght_pkg::OWN_KIND_RST, $urandom));  // at high-water
    send(req(ght_pkg::REQ_RELEASE, 255, 16'hFFFF, ght_pkg::OWN_KIND_RST, $urandom));
    send(req(ght_pkg::REQ_RELEASE, 2, 1, ght_pkg::OWN_KIND_RST, $urandom));
    send(req(ght_pkg::REQ_RELEASE, 2, 1, ght_pkg::OWN_KIND_RST, $urandom));  // stale now
    send(req(ght_pkg::REQ_LOOKUP,  2, 2, ght_pkg::OWN_KIND_RST, $urandom));  // slot free
    send(req(ght_pkg::REQ_ADD, $urandom, $urandom, $urandom, 32'h1234_5678));  // reuses 2
    send(req(ght_pkg::REQ_LOOKUP,  2, 2, ght_pkg::OWN_KIND_RST, $urandom));
    send(req(ght_pkg::REQ_RELEASE, 3, 1, ght_pkg::OWN_KIND_RST, $urandom));
    send(req(ght_pkg::REQ_RELEASE, 1, 1, ght_pkg::OWN_KIND_RST, $urandom));
    send(req(ght_pkg::REQ_ADD, $urandom, $urandom, $urandom, $urandom));  // lowest free: 1
    send(req(ght_pkg::REQ_ADD, $urandom, $urandom, $urandom, $urandom));  // then 3
    send(req(ght_pkg::REQ_ADD, $urandom, $urandom, $urandom, $urandom));  // append 4
    send(req(ght_pkg::REQ_CLEAR, $urandom, $urandom, $urandom, $urandom));
    send(req(ght_pkg::REQ_LOOKUP,  1, 2, ght_pkg::OWN_KIND_RST, $urandom));
    send(req(ght_pkg::REQ_ADD, $urandom, $urandom, $urandom, $urandom));  // append 1, epoch 1
    send(req(ght_pkg::REQ_CLEAR, $urandom, $urandom, $urandom, $urandom));
    drain();

    // Balanced mix at kind 0; long receiver hold-off in the middle.
    write_kind('0);
    for (k = 0; k < 50; k++) begin
      if (k == 25) rx_hold_asks++;
      send(random_request(35, 25, 20, 15, 5));
    end
    drain();

    // Fill to capacity at kind 255, hit full a few times, then churn while
    // nearly full so freed slots get reused.
    write_kind('1);
    k = 0;
    while (full_answers < 4 && k < 1000) begin
      send(random_request(85, 5, 4, 6, 0));
      k++;
    end
    repeat (30) send(random_request(30, 30, 30, 10, 0));
    drain();

    // Release-heavy mix at some middle kind.
    write_kind(ght_pkg::KIND_W'($urandom_range(2, 254)));
    repeat (40) send(random_request(20, 35, 35, 10, 2));
    drain();

    // From here on no idling. Walk one slot through several generations
    // with release/add pairs, then probe a stale and the current handle.
    write_kind(ght_pkg::OWN_KIND_RST);
    calm = 1'b1;
    send(req(ght_pkg::REQ_CLEAR, $urandom, $urandom, $urandom, $urandom));
    send(req(ght_pkg::REQ_ADD, $urandom, $urandom, $urandom, $urandom));
    ep = ght_pkg::EPOCH_W'(1);
    last = ep;
    for (k = 0; k < 8; k++) begin
      send(req(ght_pkg::REQ_RELEASE, 1, ep, ght_pkg::OWN_KIND_RST, $urandom));
      send(req(ght_pkg::REQ_ADD, $urandom, $urandom, $urandom, $urandom));
      last = ep;
      ep = ep + 1'b1;
    end
    send(req(ght_pkg::REQ_LOOKUP, 1, last, ght_pkg::OWN_KIND_RST, $urandom));  // stale
    send(req(ght_pkg::REQ_LOOKUP, 1, ep, ght_pkg::OWN_KIND_RST, $urandom));
    repeat (30) send(random_request(35, 25, 20, 15, 5));
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
